### hw/rtl/alm_pkg.sv
// Shared types and constants of the audio block level monitor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package alm_pkg;

   // Widths of the interval accumulators.
   localparam int SUM_BITS      = 48;
   localparam int COUNT_BITS    = 32;
   localparam int MEAN_BITS     = 16;
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

   // Queue between the front and the back (a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_BLOCK_SAMPLES   = 2'd0;
   localparam logic [1:0] REG_CHANNEL_SAMPLES = 2'd1;
   localparam logic [1:0] REG_SLOT_COUNT      = 2'd2;
   localparam logic [1:0] REG_REPORT_PERIOD   = 2'd3;

   // Reset values of the registers.
   localparam logic [15:0] RST_BLOCK_SAMPLES   = 16'd320;
   localparam logic [15:0] RST_CHANNEL_SAMPLES = 16'd160;
   localparam logic [8:0]  RST_SLOT_COUNT      = 9'd4;
   localparam logic [15:0] RST_REPORT_PERIOD   = 16'd1000;

   // Reset values of the running extremes.
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   // Item commands, coded as they arrive on the input channel.
   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_END    = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef struct packed {
      logic [15:0] block_samples;
      logic [15:0] channel_samples;
      logic [8:0]  slot_count;
      logic [15:0] report_period;
   } cfg_type;

   // Classified item as it travels through the queue. data holds the drop
   // count of a header or the raw sample in its low half.
   typedef struct packed {
      op_type      op;
      logic        ok;
      logic        gap;
      logic [31:0] data;
   } item_type;

endpackage

`default_nettype wire

### hw/rtl/alm_queue.sv
// Short queue of classified items between the front and the back.
// Depends on alm_pkg.
`default_nettype none

module alm_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  alm_pkg::item_type   push_item,
   output logic                full,
   input  wire                 pop,
   output logic                head_valid,
   output alm_pkg::item_type   head_item
);

   alm_pkg::item_type                entries_ff [alm_pkg::QUEUE_DEPTH];
   logic [alm_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [alm_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [alm_pkg::QCNT_BITS-1:0]    count_ff, count_in;

   assign full       = (count_ff == alm_pkg::QCNT_BITS'(alm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == alm_pkg::QCNT_BITS'($past(count_ff) + 1'b1))
      else $error("queue fill count lost a transfer");

endmodule

`default_nettype wire

### hw/rtl/alm_front.sv
// Front part: takes input transfers, checks headers and sequence numbers,
// and queues classified items. Depends on alm_pkg.
`default_nettype none

module alm_front (
   input  wire                 clock,
   input  wire                 reset,
   input  alm_pkg::cfg_type    cfg,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [1:0]          req_command,
   input  wire  [31:0]         req_sequence_req,
   input  wire  [15:0]         req_block_samples,
   input  wire  [15:0]         req_channel_samples,
   input  wire  [7:0]          req_slot_index,
   input  wire  [31:0]         req_message_drops,
   input  wire  signed [15:0]  req_sample_value,
   output logic                push,
   output alm_pkg::item_type   push_item,
   input  wire                 queue_full
);

   logic [31:0] next_seq_ff, next_seq_in;
   logic        have_seq_ff, have_seq_in;
   logic        is_header;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign is_header = (alm_pkg::op_type'(req_command) == alm_pkg::OP_HEADER);

   always_comb begin
      push_item.op  = alm_pkg::op_type'(req_command);
      push_item.ok  = (req_block_samples == cfg.block_samples) &&
                      (req_channel_samples == cfg.channel_samples) &&
                      ({1'b0, req_slot_index} < cfg.slot_count);
      push_item.gap = have_seq_ff && (req_sequence_req != next_seq_ff);
      case (alm_pkg::op_type'(req_command))
         alm_pkg::OP_HEADER: push_item.data = req_message_drops;
         alm_pkg::OP_SAMPLE: push_item.data = {16'd0, req_sample_value};
         default:            push_item.data = '0;
      endcase

      next_seq_in = next_seq_ff;
      have_seq_in = have_seq_ff;
      if (push && is_header) begin
         next_seq_in = req_sequence_req + 32'd1;
         have_seq_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff <= '0;
         have_seq_ff <= 1'b0;
      end else begin
         next_seq_ff <= next_seq_in;
         have_seq_ff <= have_seq_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/alm_div.sv
// Restoring divider for the mean absolute value, one quotient bit a cycle.
// Depends on alm_pkg.
`default_nettype none

module alm_div (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire  [alm_pkg::SUM_BITS-1:0]       dividend,
   input  wire  [alm_pkg::COUNT_BITS-1:0]     divisor,
   output logic                               busy,
   output logic                               done,
   output logic [alm_pkg::MEAN_BITS-1:0]      quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [alm_pkg::DIV_STEP_BITS-1:0]   step_ff, step_in;
   logic [alm_pkg::SUM_BITS-1:0]        quo_ff, quo_in;
   logic [alm_pkg::COUNT_BITS-1:0]      rem_ff, rem_in;
   logic [alm_pkg::COUNT_BITS-1:0]      dsr_ff, dsr_in;
   logic [alm_pkg::COUNT_BITS:0]        trial;
   logic                                fits;

   assign busy = busy_ff || done_ff;
   assign done = done_ff;
   // A quotient that does not fit the mean field saturates.
   assign quotient = (|quo_ff[alm_pkg::SUM_BITS-1:alm_pkg::MEAN_BITS]) ?
                     '1 : quo_ff[alm_pkg::MEAN_BITS-1:0];

   always_comb begin
      trial   = {rem_ff, quo_ff[alm_pkg::SUM_BITS-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[alm_pkg::SUM_BITS-2:0], fits};
         rem_in  = fits ? alm_pkg::COUNT_BITS'(trial - {1'b0, dsr_ff})
                        : trial[alm_pkg::COUNT_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == alm_pkg::DIV_STEP_BITS'(alm_pkg::SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !done_ff)
      else $error("divider restarted while working");

endmodule

`default_nettype wire

### hw/rtl/alm_back.sv
// Back part: keeps the interval statistics, issues reports and holds the
// output register. Depends on alm_pkg and alm_div.
`default_nettype none

module alm_back (
   input  wire                 clock,
   input  wire                 reset,
   input  alm_pkg::cfg_type    cfg,
   input  wire                 head_valid,
   input  alm_pkg::item_type   head_item,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [31:0]         rsp_block_total,
   output logic [31:0]         rsp_elapsed_ticks,
   output logic [31:0]         rsp_invalid_total,
   output logic [31:0]         rsp_gap_total,
   output logic [31:0]         rsp_last_message_drops,
   output logic signed [15:0]  rsp_min_sample,
   output logic signed [15:0]  rsp_max_sample,
   output logic [15:0]         rsp_peak_level,
   output logic [15:0]         rsp_mean_level,
   output logic [31:0]         rsp_checksum
);

   logic                             block_ok_ff, block_ok_in;
   logic [31:0]                      blocks_ff, blocks_in;
   logic [31:0]                      invalid_ff, invalid_in;
   logic [31:0]                      gaps_ff, gaps_in;
   logic [31:0]                      ticks_ff, ticks_in;
   logic signed [15:0]               min_ff, min_in;
   logic signed [15:0]               max_ff, max_in;
   logic [15:0]                      peak_ff, peak_in;
   logic [alm_pkg::SUM_BITS-1:0]     abs_sum_ff, abs_sum_in;
   logic [alm_pkg::COUNT_BITS-1:0]   samples_ff, samples_in;
   logic [31:0]                      csum_ff, csum_in;
   logic [31:0]                      drops_ff, drops_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [31:0]                      rsp_blocks_ff, rsp_ticks_ff, rsp_invalid_ff;
   logic [31:0]                      rsp_gaps_ff, rsp_drops_ff, rsp_csum_ff;
   logic signed [15:0]               rsp_min_ff, rsp_max_ff;
   logic [15:0]                      rsp_peak_ff, rsp_mean_ff;

   logic                             is_report;
   logic                             report_go;
   logic                             any_samples;
   logic                             div_busy;
   logic                             div_done;
   logic [alm_pkg::MEAN_BITS-1:0]    div_quotient;
   logic signed [15:0]               smp;
   logic [15:0]                      smp_abs;

   assign smp         = $signed(head_item.data[15:0]);
   assign smp_abs     = smp[15] ? (~head_item.data[15:0] + 16'd1) : head_item.data[15:0];
   assign any_samples = (samples_ff != '0);
   assign is_report   = (head_item.op == alm_pkg::OP_END) &&
                        (ticks_ff >= {16'd0, cfg.report_period});
   assign pop         = head_valid && (!is_report || (!div_busy && !rsp_valid_ff));
   assign report_go   = pop && is_report;

   always_comb begin
      block_ok_in = block_ok_ff;
      blocks_in   = blocks_ff;
      invalid_in  = invalid_ff;
      gaps_in     = gaps_ff;
      ticks_in    = ticks_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      peak_in     = peak_ff;
      abs_sum_in  = abs_sum_ff;
      samples_in  = samples_ff;
      csum_in     = csum_ff;
      drops_in    = drops_ff;
      if (pop) begin
         case (head_item.op)
            alm_pkg::OP_HEADER: begin
               gaps_in     = gaps_ff + {31'd0, head_item.gap};
               invalid_in  = invalid_ff + {31'd0, !head_item.ok};
               block_ok_in = head_item.ok;
               drops_in    = head_item.data;
            end
            alm_pkg::OP_SAMPLE: begin
               if (block_ok_ff) begin
                  if (smp < min_ff) min_in = smp;
                  if (smp > max_ff) max_in = smp;
                  if (smp_abs > peak_ff) peak_in = smp_abs;
                  abs_sum_in = abs_sum_ff + alm_pkg::SUM_BITS'(smp_abs);
                  samples_in = samples_ff + alm_pkg::COUNT_BITS'(1);
                  csum_in    = csum_ff + {16'd0, head_item.data[15:0]};
               end
            end
            alm_pkg::OP_TICK: begin
               ticks_in = ticks_ff + 32'd1;
            end
            alm_pkg::OP_END: begin
               blocks_in   = blocks_ff + 32'd1;
               block_ok_in = 1'b0;
               if (is_report) begin
                  blocks_in  = '0;
                  invalid_in = '0;
                  gaps_in    = '0;
                  ticks_in   = '0;
                  min_in     = alm_pkg::SAMPLE_MAX;
                  max_in     = alm_pkg::SAMPLE_MIN;
                  peak_in    = '0;
                  abs_sum_in = '0;
                  samples_in = '0;
                  csum_in    = '0;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((report_go && !any_samples) || div_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ok_ff  <= 1'b0;
         blocks_ff    <= '0;
         invalid_ff   <= '0;
         gaps_ff      <= '0;
         ticks_ff     <= '0;
         min_ff       <= alm_pkg::SAMPLE_MAX;
         max_ff       <= alm_pkg::SAMPLE_MIN;
         peak_ff      <= '0;
         abs_sum_ff   <= '0;
         samples_ff   <= '0;
         csum_ff      <= '0;
         drops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         block_ok_ff  <= block_ok_in;
         blocks_ff    <= blocks_in;
         invalid_ff   <= invalid_in;
         gaps_ff      <= gaps_in;
         ticks_ff     <= ticks_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         peak_ff      <= peak_in;
         abs_sum_ff   <= abs_sum_in;
         samples_ff   <= samples_in;
         csum_ff      <= csum_in;
         drops_ff     <= drops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Report snapshot; the mean follows when the divider finishes.
   always_ff @(posedge clock) begin
      if (report_go) begin
         rsp_blocks_ff  <= blocks_ff + 32'd1;
         rsp_ticks_ff   <= ticks_ff;
         rsp_invalid_ff <= invalid_ff;
         rsp_gaps_ff    <= gaps_ff;
         rsp_drops_ff   <= drops_ff;
         rsp_min_ff     <= any_samples ? min_ff : 16'sd0;
         rsp_max_ff     <= any_samples ? max_ff : 16'sd0;
         rsp_peak_ff    <= peak_ff;
         rsp_csum_ff    <= csum_ff;
         rsp_mean_ff    <= '0;
      end else if (div_done) begin
         rsp_mean_ff    <= div_quotient;
      end
   end

   alm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (report_go && any_samples),
      .dividend (abs_sum_ff),
      .divisor  (samples_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_block_total        = rsp_blocks_ff;
   assign rsp_elapsed_ticks      = rsp_ticks_ff;
   assign rsp_invalid_total      = rsp_invalid_ff;
   assign rsp_gap_total          = rsp_gaps_ff;
   assign rsp_last_message_drops = rsp_drops_ff;
   assign rsp_min_sample         = rsp_min_ff;
   assign rsp_max_sample         = rsp_max_ff;
   assign rsp_peak_level         = rsp_peak_ff;
   assign rsp_mean_level         = rsp_mean_ff;
   assign rsp_checksum           = rsp_csum_ff;

   a_report_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      report_go |-> !rsp_valid_ff && !div_busy)
      else $error("report started over a pending result");

   a_done_presents: assert property (@(posedge clock) disable iff (reset)
      div_done |=> rsp_valid_ff)
      else $error("finished mean not presented");

endmodule

`default_nettype wire

### hw/rtl/audio_block_level_monitor.sv
// Top level of the audio block level monitor: configuration registers and
// the front, queue and back parts. Depends on alm_pkg and all alm_ modules.
`default_nettype none

// The monitor takes one item per transfer on the req_ channel: a block
// header, a PCM sample, a block end or a time tick. Headers, samples, ticks
// and block ends that give no report never hold up the back part, so a
// steady stream of one item per cycle is sustained while the queue has room.
// When a block end closes a reporting interval that held samples, the
// bit-serial divider forms the mean absolute value in 48 steps, and the mean
// is then loaded into the result register; the result transfer follows on
// the rsp_ channel. While the divider works or a result waits to be taken,
// a four-entry queue behind the input keeps accepting items while it has
// room, and other items still update the statistics; only a second reporting
// block end waits until the divider is idle and the output register is free.
// The four configuration registers sit at byte addresses 0, 4, 8 and 12 and
// should only be written while the monitor is idle.
module audio_block_level_monitor (
   input  wire                clock,
   input  wire                reset,
   // Input channel
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_command,
   input  wire  [31:0]        req_sequence_req,
   input  wire  [15:0]        req_block_samples,
   input  wire  [15:0]        req_channel_samples,
   input  wire  [7:0]         req_slot_index,
   input  wire  [31:0]        req_message_drops,
   input  wire  signed [15:0] req_sample_value,
   // Result channel
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [31:0]        rsp_block_total,
   output logic [31:0]        rsp_elapsed_ticks,
   output logic [31:0]        rsp_invalid_total,
   output logic [31:0]        rsp_gap_total,
   output logic [31:0]        rsp_last_message_drops,
   output logic signed [15:0] rsp_min_sample,
   output logic signed [15:0] rsp_max_sample,
   output logic [15:0]        rsp_peak_level,
   output logic [15:0]        rsp_mean_level,
   output logic [31:0]        rsp_checksum,
   // Configuration port
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [3:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   alm_pkg::cfg_type  cfg_ff, cfg_in;
   logic              cfg_write;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              head_valid;
   alm_pkg::item_type push_item;
   alm_pkg::item_type head_item;

   // The register port never inserts wait states.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (paddr[3:2])
            alm_pkg::REG_BLOCK_SAMPLES:   cfg_in.block_samples   = pwdata[15:0];
            alm_pkg::REG_CHANNEL_SAMPLES: cfg_in.channel_samples = pwdata[15:0];
            alm_pkg::REG_SLOT_COUNT:      cfg_in.slot_count      = pwdata[8:0];
            alm_pkg::REG_REPORT_PERIOD:   cfg_in.report_period   = pwdata[15:0];
            default: begin
            end
         endcase
      end

      case (paddr[3:2])
         alm_pkg::REG_BLOCK_SAMPLES:   prdata = {16'd0, cfg_ff.block_samples};
         alm_pkg::REG_CHANNEL_SAMPLES: prdata = {16'd0, cfg_ff.channel_samples};
         alm_pkg::REG_SLOT_COUNT:      prdata = {23'd0, cfg_ff.slot_count};
         alm_pkg::REG_REPORT_PERIOD:   prdata = {16'd0, cfg_ff.report_period};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_samples   <= alm_pkg::RST_BLOCK_SAMPLES;
         cfg_ff.channel_samples <= alm_pkg::RST_CHANNEL_SAMPLES;
         cfg_ff.slot_count      <= alm_pkg::RST_SLOT_COUNT;
         cfg_ff.report_period   <= alm_pkg::RST_REPORT_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front checks headers and sequence numbers as items arrive.
   alm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_sequence_req    (req_sequence_req),
      .req_block_samples   (req_block_samples),
      .req_channel_samples (req_channel_samples),
      .req_slot_index      (req_slot_index),
      .req_message_drops   (req_message_drops),
      .req_sample_value    (req_sample_value),
      .push                (push),
      .push_item           (push_item),
      .queue_full          (queue_full)
   );

   // The queue lets the front keep taking transfers while a report is formed.
   alm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // The back accumulates the interval statistics and drives the results.
   alm_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .head_valid             (head_valid),
      .head_item              (head_item),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_block_total        (rsp_block_total),
      .rsp_elapsed_ticks      (rsp_elapsed_ticks),
      .rsp_invalid_total      (rsp_invalid_total),
      .rsp_gap_total          (rsp_gap_total),
      .rsp_last_message_drops (rsp_last_message_drops),
      .rsp_min_sample         (rsp_min_sample),
      .rsp_max_sample         (rsp_max_sample),
      .rsp_peak_level         (rsp_peak_level),
      .rsp_mean_level         (rsp_mean_level),
      .rsp_checksum           (rsp_checksum)
   );

endmodule

`default_nettype wire
